### hdl/mpq_pkg.sv
// Package for the linear-scan min priority queue.
// Holds capacity constants, action/status/state codes and shared structs.
// No dependencies.
package mpq_pkg;

    localparam int CAPACITY    = 64;
    localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int DATA_W      = 32;
    localparam int COUNT_OUT_W = 7;

    typedef enum logic [1:0] {
        ACT_ENQ   = 2'd0,
        ACT_DEQ   = 2'd1,
        ACT_PEEK  = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_MOVE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic        [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } t_entry;

    typedef struct packed {
        logic              first;
        logic              valid;
        logic [ADDR_W-1:0] slot;
    } t_scan_ctl;

    typedef struct packed {
        t_status          status;
        t_entry           entry;
        logic [CNT_W-1:0] count;
    } t_result;

    // Biased priority above value: unsigned compare gives the urgency order.
    function automatic logic [2*DATA_W-1:0] urgency_key(input t_entry e);
        urgency_key = {e.prio ^ {1'b1, {(DATA_W-1){1'b0}}}, e.value};
    endfunction

endpackage

### hdl/mpq_store.sv
// Entry store for the priority queue: one write port, one registered read.
// Depends on mpq_pkg.
module mpq_store (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [mpq_pkg::ADDR_W-1:0]  i_waddr,
    input  mpq_pkg::t_entry             i_wdata,
    input  logic                        i_re,
    input  logic [mpq_pkg::ADDR_W-1:0]  i_raddr,
    output mpq_pkg::t_entry             o_rdata
);
    import mpq_pkg::*;

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/mpq_scan.sv
// Shared compare unit: keeps the most urgent entry seen during a scan.
// Depends on mpq_pkg.
module mpq_scan (
    input  logic                        i_clk,
    input  mpq_pkg::t_scan_ctl          i_ctl,
    input  mpq_pkg::t_entry             i_entry,
    output mpq_pkg::t_entry             o_best,
    output logic [mpq_pkg::ADDR_W-1:0]  o_best_slot
);
    import mpq_pkg::*;

    t_entry            r_best;
    logic [ADDR_W-1:0] r_best_slot;
    logic              take;

    assign take = i_ctl.valid && (i_ctl.first || (urgency_key(i_entry) < urgency_key(r_best)));

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best      <= i_entry;
            r_best_slot <= i_ctl.slot;
        end
    end

    assign o_best      = r_best;
    assign o_best_slot = r_best_slot;

endmodule

### hdl/mpq_ctrl.sv
// Sequencer for the priority queue: accepts a request, drives the store
// and the compare unit over the scan, and produces one result.
// Depends on mpq_pkg.
module mpq_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_action,
    input  logic [mpq_pkg::DATA_W-1:0]  i_value,
    input  logic [mpq_pkg::DATA_W-1:0]  i_priority_req,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output mpq_pkg::t_result            o_res,
    output logic                        o_we,
    output logic [mpq_pkg::ADDR_W-1:0]  o_waddr,
    output mpq_pkg::t_entry             o_wdata,
    output logic                        o_re,
    output logic [mpq_pkg::ADDR_W-1:0]  o_raddr,
    input  mpq_pkg::t_entry             i_rdata,
    output mpq_pkg::t_scan_ctl          o_cmp,
    input  mpq_pkg::t_entry             i_best,
    input  logic [mpq_pkg::ADDR_W-1:0]  i_best_slot
);
    import mpq_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    t_action           r_action, n_action;
    logic [ADDR_W-1:0] r_idx, n_idx;
    t_scan_ctl         r_cmp, n_cmp;
    t_status           r_status, n_status;
    t_entry            r_res, n_res;

    t_action           act_in;
    logic              full;
    logic [ADDR_W-1:0] last_idx;

    assign act_in   = t_action'(i_action);
    assign full     = (r_count == CNT_W'(CAPACITY));
    assign last_idx = ADDR_W'(r_count - CNT_W'(1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if ((act_in inside {ACT_DEQ, ACT_PEEK}) && (r_count != '0)) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (r_idx == last_idx) begin
                    n_state = S_LAST;
                end
            end
            S_LAST:  n_state = S_MOVE;
            S_MOVE:  n_state = S_DONE;
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_we     = 1'b0;
        o_waddr  = r_count[ADDR_W-1:0];
        o_wdata  = '{value: i_value, prio: i_priority_req};
        o_re     = 1'b0;
        o_raddr  = r_idx;
        n_count  = r_count;
        n_action = r_action;
        n_idx    = r_idx;
        n_cmp    = '{first: 1'b0, valid: 1'b0, slot: r_idx};
        n_status = r_status;
        n_res    = r_res;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_action = act_in;
                    n_status = ST_OK;
                    n_res    = '0;
                    n_idx    = '0;
                    case (act_in)
                        ACT_ENQ: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_we    = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        ACT_DEQ, ACT_PEEK: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end
                        end
                        ACT_CLEAR: n_count = '0;
                        default:   n_count = r_count;
                    endcase
                end
            end
            S_SCAN: begin
                o_re  = 1'b1;
                o_raddr = r_idx;
                n_idx = r_idx + ADDR_W'(1);
                n_cmp = '{first: (r_idx == '0), valid: 1'b1, slot: r_idx};
            end
            S_LAST: begin
                o_re    = 1'b1;
                o_raddr = last_idx;
            end
            S_MOVE: begin
                n_res = i_best;
                if (r_action == ACT_DEQ) begin
                    o_we    = 1'b1;
                    o_waddr = i_best_slot;
                    o_wdata = i_rdata;
                    n_count = r_count - CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cmp   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cmp   <= n_cmp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_res    <= n_res;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = '{status: r_status, entry: r_res, count: r_count};
    assign o_cmp       = r_cmp;

endmodule

### hdl/min_priority_queue_linear_scan_top.sv
// Min priority queue over an unsorted store, scanned by one comparator.
// Depends on mpq_pkg, mpq_store, mpq_scan, mpq_ctrl.
//
// Input channel (i_valid/o_ready) carries a request: enqueue, dequeue,
// peek or clear. Output channel (o_valid/i_ready) returns one result per
// request: status, the most urgent entry for a good dequeue or peek,
// and the entry count after the request.
// Enqueue, clear, and dequeue/peek on an empty queue: the sequencer goes
// straight from idle to done, the result is then registered into the output
// register, and the next request is accepted once the sequencer is idle again.
// Dequeue and peek read one stored entry per cycle into the shared
// comparator, then fetch the last entry (S_LAST) and, on a dequeue, move it
// into the hole left by the taken entry (S_MOVE) before the result is ready.
// o_ready is high only while the sequencer is idle.
// Reset empties the queue and drops any pending result.
// If the receiver stalls, the result holds in the output register; one
// more request may finish into the sequencer, which then waits.
module min_priority_queue_linear_scan_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [1:0]                           i_action,
    input  logic [31:0]                          i_value,
    input  logic signed [31:0]                   i_priority_req,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [1:0]                           o_status,
    output logic [31:0]                          o_out_value,
    output logic signed [31:0]                   o_out_priority,
    output logic [mpq_pkg::COUNT_OUT_W-1:0]      o_count,
    output logic                                 o_is_empty
);
    import mpq_pkg::*;

    logic              res_valid, res_ready;
    t_result           res;
    logic              we, re;
    logic [ADDR_W-1:0] waddr, raddr;
    t_entry            wdata, rdata, best;
    logic [ADDR_W-1:0] best_slot;
    t_scan_ctl         cmp;

    logic              r_out_valid;
    t_result           r_out;

    mpq_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_value        (i_value),
        .i_priority_req (i_priority_req),
        .o_res_valid    (res_valid),
        .i_res_ready    (res_ready),
        .o_res          (res),
        .o_we           (we),
        .o_waddr        (waddr),
        .o_wdata        (wdata),
        .o_re           (re),
        .o_raddr        (raddr),
        .i_rdata        (rdata),
        .o_cmp          (cmp),
        .i_best         (best),
        .i_best_slot    (best_slot)
    );

    mpq_store u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    mpq_scan u_scan (
        .i_clk       (i_clk),
        .i_ctl       (cmp),
        .i_entry     (rdata),
        .o_best      (best),
        .o_best_slot (best_slot)
    );

    assign res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out.status;
    assign o_out_value    = r_out.entry.value;
    assign o_out_priority = r_out.entry.prio;
    assign o_count        = COUNT_OUT_W'(r_out.count);
    assign o_is_empty     = (r_out.count == '0);

endmodule

### hdl/mpq_checker.sv
// Port-level checks for the priority queue top level, with its bind.
// Depends on mpq_pkg and min_priority_queue_linear_scan_top.
module mpq_port_checks (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 o_ready,
    input  logic [1:0]                           i_action,
    input  logic [31:0]                          i_value,
    input  logic signed [31:0]                   i_priority_req,
    input  logic                                 o_valid,
    input  logic                                 i_ready,
    input  logic [1:0]                           o_status,
    input  logic [31:0]                          o_out_value,
    input  logic signed [31:0]                   o_out_priority,
    input  logic [mpq_pkg::COUNT_OUT_W-1:0]      o_count,
    input  logic                                 o_is_empty
);
    import mpq_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_out_value)
            && $stable(o_out_priority) && $stable(o_count))
        else $error("result beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("request accepted back to back");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> (o_count == COUNT_OUT_W'(CAPACITY)) && !o_is_empty)
        else $error("full status with a short store");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_out_value == '0) && (o_out_priority == '0))
        else $error("error result carries an entry");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> o_is_empty && (o_count == '0))
        else $error("empty status with stored entries");

endmodule

bind min_priority_queue_linear_scan_top mpq_port_checks u_mpq_port_checks (.*);

### dv/mpq_checker.sv
// Result checker for the linear-scan min priority queue: watches both channels,
// predicts each result from its own copy of the store and compares field by field.
// Depends on mpq_pkg.
module mpq_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic                            i_req_ready,
    input  logic [1:0]                      i_req_action,
    input  logic [31:0]                     i_req_value,
    input  logic signed [31:0]              i_req_priority,
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  logic [1:0]                      i_res_status,
    input  logic [31:0]                     i_res_value,
    input  logic signed [31:0]              i_res_priority,
    input  logic [mpq_pkg::COUNT_OUT_W-1:0] i_res_count,
    input  logic                            i_res_is_empty,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked,
    output int                              o_full_seen,
    output int                              o_empty_seen
);
    import mpq_pkg::*;

    typedef struct {
        t_status                  status;
        logic [31:0]              value;
        logic signed [31:0]       prio;
        logic [COUNT_OUT_W-1:0]   count;
        logic                     is_empty;
    } t_outcome;

    logic [31:0]        held_value [CAPACITY];
    logic signed [31:0] held_prio  [CAPACITY];
    int                 held_count;
    t_outcome           pending_results [$];

    int fail_count  = 0;
    int checked     = 0;
    int full_seen   = 0;
    int empty_seen  = 0;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 50) begin
            $display("ERROR @%0t result %0d: %s", $time, checked, msg);
        end
    endtask

    // Updates the held store and queues the result this request must produce.
    task automatic serve_request(input t_action act, input logic [31:0] val,
                                 input logic signed [31:0] pri);
        t_outcome    r;
        int          best;
        logic [63:0] best_key;
        logic [63:0] key;
        r.status = ST_OK;
        r.value  = '0;
        r.prio   = '0;
        case (act)
            ACT_ENQ: begin
                if (held_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    held_value[held_count] = val;
                    held_prio[held_count]  = pri;
                    held_count++;
                end
            end
            ACT_DEQ, ACT_PEEK: begin
                if (held_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // smallest priority wins, ties to the smaller value
                    best     = 0;
                    best_key = {held_prio[0] ^ 32'h8000_0000, held_value[0]};
                    for (int k = 1; k < held_count; k++) begin
                        key = {held_prio[k] ^ 32'h8000_0000, held_value[k]};
                        if (key < best_key) begin
                            best_key = key;
                            best     = k;
                        end
                    end
                    r.value = held_value[best];
                    r.prio  = held_prio[best];
                    if (act == ACT_DEQ) begin
                        held_value[best] = held_value[held_count-1];
                        held_prio[best]  = held_prio[held_count-1];
                        held_count--;
                    end
                end
            end
            default: begin
                held_count = 0;
            end
        endcase
        r.count    = held_count[COUNT_OUT_W-1:0];
        r.is_empty = (held_count == 0);
        pending_results.push_back(r);
    endtask

    task automatic check_result();
        t_outcome want;
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected beat: status %0d value %08h prio %0d",
                                      i_res_status, i_res_value, i_res_priority));
            return;
        end
        want = pending_results.pop_front();
        if (t_status'(i_res_status) != want.status)
            report_mismatch($sformatf("status got %0d exp %0d", i_res_status, want.status));
        if (i_res_value !== want.value)
            report_mismatch($sformatf("value got %08h exp %08h", i_res_value, want.value));
        if (i_res_priority !== want.prio)
            report_mismatch($sformatf("priority got %0d exp %0d",
                                      i_res_priority, want.prio));
        if (i_res_count !== want.count)
            report_mismatch($sformatf("count got %0d exp %0d", i_res_count, want.count));
        if (i_res_is_empty !== want.is_empty)
            report_mismatch($sformatf("is_empty got %0b exp %0b",
                                      i_res_is_empty, want.is_empty));
        if (want.status == ST_FULL) full_seen++;
        if (want.status == ST_EMPTY) empty_seen++;
        checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 0;
            pending_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) check_result();
            if (i_req_valid && i_req_ready) begin
                serve_request(t_action'(i_req_action), i_req_value, i_req_priority);
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_results.size();
        o_checked    <= checked;
        o_full_seen  <= full_seen;
        o_empty_seen <= empty_seen;
    end

endmodule

### dv/testbench.sv
// Top of the priority queue testbench: clock, reset, request stimulus and
// result back-pressure; verdict taken from mpq_checker.
// Depends on mpq_pkg, mpq_checker and min_priority_queue_linear_scan_top.
module testbench;
    import mpq_pkg::*;

    localparam int RANDOM_ITEMS = 1130;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_valid        = 1'b0;
    logic [1:0]             i_action       = ACT_ENQ;
    logic [31:0]            i_value        = '0;
    logic signed [31:0]     i_priority_req = '0;
    logic                   i_ready        = 1'b0;
    logic                   o_ready;
    logic                   o_valid;
    logic [1:0]             o_status;
    logic [31:0]            o_out_value;
    logic signed [31:0]     o_out_priority;
    logic [COUNT_OUT_W-1:0] o_count;
    logic                   o_is_empty;

    int fail_count;
    int pending;
    int checked;
    int full_seen;
    int empty_seen;
    int burst_left = 0;
    int action_tally [4] = '{0, 0, 0, 0};
    int ready_phase = 0;
    int ready_mode  = 0;

    always #5 i_clk = ~i_clk;

    min_priority_queue_linear_scan_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_value        (i_value),
        .i_priority_req (i_priority_req),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_out_value    (o_out_value),
        .o_out_priority (o_out_priority),
        .o_count        (o_count),
        .o_is_empty     (o_is_empty)
    );

    mpq_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_ready    (o_ready),
        .i_req_action   (i_action),
        .i_req_value    (i_value),
        .i_req_priority (i_priority_req),
        .i_res_valid    (o_valid),
        .i_res_ready    (i_ready),
        .i_res_status   (o_status),
        .i_res_value    (o_out_value),
        .i_res_priority (o_out_priority),
        .i_res_count    (o_count),
        .i_res_is_empty (o_is_empty),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_full_seen    (full_seen),
        .o_empty_seen   (empty_seen)
    );

    // receiver back-pressure: ready_mode picks one of four patterns and is re-drawn at random
    always @(posedge i_clk) begin
        ready_phase <= ready_phase + 1;
        if (ready_phase % 300 == 0) ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
            0:       i_ready <= 1'b1;
            1:       i_ready <= ($urandom_range(0, 3) != 0);
            2:       i_ready <= ((ready_phase % 7) < 4);
            default: i_ready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    // mix of full-range words, small numbers (ties) and words near the extremes
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0, 1, 2: pick_word = $urandom;
            3, 4:    pick_word = $urandom_range(0, 3);
            5:       pick_word = 32'h8000_0000 + $urandom_range(0, 2);
            6:       pick_word = 32'h7FFF_FFFF - $urandom_range(0, 2);
            default: pick_word = 32'hFFFF_FFFF - $urandom_range(0, 2);
        endcase
    endfunction

    task automatic send(input t_action act, input logic [31:0] val,
                        input logic [31:0] pri);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_valid        <= 1'b1;
        i_action       <= act;
        i_value        <= val;
        i_priority_req <= pri;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        burst_left--;
        action_tally[act]++;
    endtask

    // 0: fill toward full, 1: drain toward empty, 2: mixed
    task automatic send_random(input int mode);
        int      r;
        t_action act;
        r = $urandom_range(0, 99);
        case (mode)
            0:       act = (r < 94) ? ACT_ENQ : (r < 97) ? ACT_PEEK : ACT_DEQ;
            1:       act = (r < 55) ? ACT_DEQ : (r < 85) ? ACT_PEEK :
                           (r < 98) ? ACT_ENQ : ACT_CLEAR;
            default: act = (r < 40) ? ACT_ENQ : (r < 65) ? ACT_DEQ :
                           (r < 97) ? ACT_PEEK : ACT_CLEAR;
        endcase
        send(act, pick_word(), pick_word());
    endtask

    initial begin
        int sent;
        int mode;
        int len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty queue, extremes, priority ties broken by value
        send(ACT_PEEK, $urandom, $urandom);
        send(ACT_DEQ, $urandom, $urandom);
        send(ACT_ENQ, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send(ACT_ENQ, 32'h0000_0000, 32'h8000_0000);
        send(ACT_ENQ, 32'd5, 32'hFFFF_FFFF);
        send(ACT_ENQ, 32'd3, 32'hFFFF_FFFF);
        send(ACT_ENQ, 32'd7, 32'hFFFF_FFFF);
        send(ACT_ENQ, 32'h1234_5678, 32'd0);
        send(ACT_PEEK, $urandom, $urandom);
        repeat (6) send(ACT_DEQ, $urandom, $urandom);
        send(ACT_PEEK, $urandom, $urandom);
        send(ACT_DEQ, $urandom, $urandom);
        send(ACT_ENQ, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
        send(ACT_ENQ, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
        send(ACT_CLEAR, $urandom, $urandom);
        send(ACT_PEEK, $urandom, $urandom);
        send(ACT_CLEAR, $urandom, $urandom);
        send(ACT_ENQ, $urandom, $urandom);
        send(ACT_DEQ, $urandom, $urandom);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 2);
            len  = (mode == 0) ? $urandom_range(40, 110) : $urandom_range(10, 80);
            if (len > RANDOM_ITEMS - sent) len = RANDOM_ITEMS - sent;
            repeat (len) send_random(mode);
            sent += len;
        end
        i_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("Sent %0d requests: %0d enqueue, %0d dequeue, %0d peek, %0d clear",
                 action_tally[0] + action_tally[1] + action_tally[2] + action_tally[3],
                 action_tally[ACT_ENQ], action_tally[ACT_DEQ],
                 action_tally[ACT_PEEK], action_tally[ACT_CLEAR]);
        $display("Checked %0d results; enqueue on full store %0d, empty store reads %0d",
                 checked, full_seen, empty_seen);
        if (fail_count == 0) begin
            $display("min_priority_queue_linear_scan_top verification clean");
        end else begin
            $display("min_priority_queue_linear_scan_top verification failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Timeout: %0d results still outstanding", pending);
        $display("min_priority_queue_linear_scan_top verification failed");
        $finish;
    end

endmodule
